### hdl/tmc_pkg.sv
// Package for the thruster mixer and clamp block.
// Holds field widths, register indexes, reset values and the item structs.
// No dependencies; used by tmc_mix and thruster_mixer_clamp_top.
`default_nettype none

package tmc_pkg;

   localparam int CMD_W   = 11;
   localparam int CORR_W  = 12;
   localparam int PW_W    = 16;
   localparam int SUM_W   = 19;
   localparam int NUM_OUT = 8;
   localparam int REQ_W   = 4 * CMD_W + 3 * CORR_W;
   localparam int RSP_W   = NUM_OUT * PW_W;
   localparam int CSR_A_W = 2;

   localparam logic [CSR_A_W-1:0] CSR_NEUTRAL    = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_CLAMP_HIGH = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_CLAMP_LOW  = 2'd2;

   localparam logic [PW_W-1:0] NEUTRAL_RST    = 16'd1500;
   localparam logic [PW_W-1:0] CLAMP_HIGH_RST = 16'd2750;
   localparam logic [PW_W-1:0] CLAMP_LOW_RST  = 16'd1750;

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic [PW_W-1:0] pw_type;

   // surge in the lowest bits
   typedef struct packed {
      logic signed [CORR_W-1:0] yaw_corr;
      logic signed [CORR_W-1:0] roll_corr;
      logic signed [CORR_W-1:0] pitch_corr;
      logic signed [CMD_W-1:0]  turn;
      logic signed [CMD_W-1:0]  heave;
      logic signed [CMD_W-1:0]  sway;
      logic signed [CMD_W-1:0]  surge;
   } req_type;

   typedef struct packed {
      pw_type neutral_width;
      pw_type clamp_high;
      pw_type clamp_low;
   } lim_type;

   // width_m1 in the lowest bits
   typedef struct packed {
      pw_type width_m8;
      pw_type width_m7;
      pw_type width_m6;
      pw_type width_m5;
      pw_type width_m4;
      pw_type width_m3;
      pw_type width_m2;
      pw_type width_m1;
   } rsp_type;

endpackage

`default_nettype wire

### hdl/thruster_mixer_clamp_top.sv
// Top level of the eight-thruster mixer with pulse-width clamping.
// Depends on tmc_pkg and tmc_mix.
//
// Usage:
//   req_* carries one command item per handshake: four stick commands,
//   three correction terms in tdata and the link-lost flag in tuser.
//   rsp_* returns one item of eight 16-bit pulse widths per request.
//   csr_* writes neutral width (0), clamp high (1) and clamp low (2);
//   other indexes are ignored. Write only while no item is in flight.
// Path: an accepted item is registered in the input register, mixed and
//   clamped combinationally, then shows on rsp_tvalid from the result register.
// Throughput: one item per cycle while rsp_tready is high; the input
//   and result registers form a two-stage pipeline with per-stage valid bits.
// Stall: while rsp_tready is low the result holds; the input stage still
//   takes one more item, then req_tready drops until the result moves.
// Reset: clears both valid bits and loads the limit registers with their
//   defaults (1500, 2750, 1750).
`default_nettype none

module thruster_mixer_clamp_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // surge, sway, heave, turn (11 bit), pitch_corr, roll_corr, yaw_corr (12 bit)
   input  logic [tmc_pkg::REQ_W-1:0]           req_tdata,
   // link_lost
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // width_m1 .. width_m8, 16 bit each
   output logic [tmc_pkg::RSP_W-1:0]           rsp_tdata,
   input  logic                                csr_we,
   input  logic [tmc_pkg::CSR_A_W-1:0]         csr_addr,
   input  logic [tmc_pkg::PW_W-1:0]            csr_wdata
);
   import tmc_pkg::*;

   logic    in_vld_ff, in_vld_in;
   req_type in_item_ff;
   logic    in_lost_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_data_ff;
   rsp_type mix_result;
   lim_type lim_ff, lim_in;
   logic    out_ready;

   assign out_ready  = !out_vld_ff || rsp_tready;
   assign req_tready = !in_vld_ff || out_ready;
   assign in_vld_in  = req_tready ? req_tvalid : in_vld_ff;
   assign out_vld_in = out_ready ? in_vld_ff : out_vld_ff;

   always_comb begin
      lim_in = lim_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_NEUTRAL:    lim_in.neutral_width = csr_wdata;
            CSR_CLAMP_HIGH: lim_in.clamp_high    = csr_wdata;
            CSR_CLAMP_LOW:  lim_in.clamp_low     = csr_wdata;
            default:        lim_in = lim_ff;
         endcase
      end
   end

   tmc_mix u_mix (
      .item      (in_item_ff),
      .link_lost (in_lost_ff),
      .lim       (lim_ff),
      .result    (mix_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff            <= 1'b0;
         out_vld_ff           <= 1'b0;
         lim_ff.neutral_width <= NEUTRAL_RST;
         lim_ff.clamp_high    <= CLAMP_HIGH_RST;
         lim_ff.clamp_low     <= CLAMP_LOW_RST;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         lim_ff     <= lim_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_type'(req_tdata);
         in_lost_ff <= req_tuser;
      end
      if (in_vld_ff && out_ready) begin
         out_data_ff <= mix_result;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RSP_W'(out_data_ff);

endmodule

`default_nettype wire

### hdl/tmc_mix.sv
// Mix and clamp logic for one item: eight signed sums around neutral,
// each clamped to the limits, or all neutral on link loss.
// Depends on tmc_pkg.
`default_nettype none

module tmc_mix (
   input  tmc_pkg::req_type item,
   input  logic             link_lost,
   input  tmc_pkg::lim_type lim,
   output tmc_pkg::rsp_type result
);
   import tmc_pkg::*;

   sum_type n, sx, sy, sz, st, cp, cr, cy;
   sum_type hi, lo;
   sum_type v1, v2, v3, v4, v5, v6, v7, v8;

   function automatic pw_type clamp_pw(input sum_type v, input sum_type h, input sum_type l);
      pw_type r;
      if (v > h) begin
         r = h[PW_W-1:0];
      end else if (v < l) begin
         r = l[PW_W-1:0];
      end else begin
         r = v[PW_W-1:0];
      end
      return r;
   endfunction

   assign n  = sum_type'(lim.neutral_width);
   assign hi = sum_type'(lim.clamp_high);
   assign lo = sum_type'(lim.clamp_low);
   assign sx = sum_type'(item.surge);
   assign sy = sum_type'(item.sway);
   assign sz = sum_type'(item.heave);
   assign st = sum_type'(item.turn);
   assign cp = sum_type'(item.pitch_corr);
   assign cr = sum_type'(item.roll_corr);
   assign cy = sum_type'(item.yaw_corr);

   assign v1 = n + sz + cp + cr;
   assign v2 = n - sz - cp - cr;
   assign v3 = n + sz + cp - cr;
   assign v4 = n - sz - cp + cr;
   assign v5 = n + sx + sy + st - cy;
   assign v6 = n + sx + sy - st + cy;
   assign v7 = n + sx - sy + st - cy;
   assign v8 = n + sx - sy - st + cy;

   always_comb begin
      if (link_lost) begin
         result.width_m1 = lim.neutral_width;
         result.width_m2 = lim.neutral_width;
         result.width_m3 = lim.neutral_width;
         result.width_m4 = lim.neutral_width;
         result.width_m5 = lim.neutral_width;
         result.width_m6 = lim.neutral_width;
         result.width_m7 = lim.neutral_width;
         result.width_m8 = lim.neutral_width;
      end else begin
         result.width_m1 = clamp_pw(v1, hi, lo);
         result.width_m2 = clamp_pw(v2, hi, lo);
         result.width_m3 = clamp_pw(v3, hi, lo);
         result.width_m4 = clamp_pw(v4, hi, lo);
         result.width_m5 = clamp_pw(v5, hi, lo);
         result.width_m6 = clamp_pw(v6, hi, lo);
         result.width_m7 = clamp_pw(v7, hi, lo);
         result.width_m8 = clamp_pw(v8, hi, lo);
      end
   end

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for thruster_mixer_clamp_top: random and directed command items,
// random stalls on both stream sides, and register changes between phases.
// Depends on tmc_pkg and the block's RTL; a scoreboard class predicts all eight widths.
`default_nettype none

module testbench;
   import tmc_pkg::*;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int ITEMS_PER_PHASE  = 125;
   localparam int NUM_PHASES       = 8;
   localparam int DRAIN_CYCLES     = 4;

   localparam logic [CSR_A_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic signed [CMD_W-1:0]  STICK_MIN = {1'b1, {(CMD_W-1){1'b0}}};
   localparam logic signed [CMD_W-1:0]  STICK_MAX = {1'b0, {(CMD_W-1){1'b1}}};
   localparam logic signed [CORR_W-1:0] CORR_MIN  = {1'b1, {(CORR_W-1){1'b0}}};
   localparam logic signed [CORR_W-1:0] CORR_MAX  = {1'b0, {(CORR_W-1){1'b1}}};

   class mix_scoreboard;
      pw_type           neutral_width;
      pw_type           clamp_high;
      pw_type           clamp_low;
      logic [RSP_W-1:0] expected_widths[$];
      int               errors;
      int               checked;

      function new();
         load_defaults();
         errors  = 0;
         checked = 0;
      endfunction

      function void load_defaults();
         neutral_width = NEUTRAL_RST;
         clamp_high    = CLAMP_HIGH_RST;
         clamp_low     = CLAMP_LOW_RST;
      endfunction

      function void write_reg(logic [CSR_A_W-1:0] idx, pw_type value);
         case (idx)
            CSR_NEUTRAL:    neutral_width = value;
            CSR_CLAMP_HIGH: clamp_high    = value;
            CSR_CLAMP_LOW:  clamp_low     = value;
            default: ;
         endcase
      endfunction

      // high limit wins when the limits are crossed
      function pw_type clip(int value);
         if (value > int'(clamp_high)) return clamp_high;
         if (value < int'(clamp_low)) return clamp_low;
         return pw_type'(value);
      endfunction

      function void note_item(req_type cmd, logic lost);
         int               n, sx, sy, sz, st, cp, cr, cy;
         int               mix[NUM_OUT];
         logic [RSP_W-1:0] widths;
         n  = int'(neutral_width);
         sx = int'($signed(cmd.surge));
         sy = int'($signed(cmd.sway));
         sz = int'($signed(cmd.heave));
         st = int'($signed(cmd.turn));
         cp = int'($signed(cmd.pitch_corr));
         cr = int'($signed(cmd.roll_corr));
         cy = int'($signed(cmd.yaw_corr));
         mix[0] = n + sz + cp + cr;
         mix[1] = n - sz - cp - cr;
         mix[2] = n + sz + cp - cr;
         mix[3] = n - sz - cp + cr;
         mix[4] = n + sx + sy + st - cy;
         mix[5] = n + sx + sy - st + cy;
         mix[6] = n + sx - sy + st - cy;
         mix[7] = n + sx - sy - st + cy;
         for (int k = 0; k < NUM_OUT; k++)
            widths[k*PW_W +: PW_W] = lost ? neutral_width : clip(mix[k]);
         expected_widths.push_back(widths);
      endfunction

      function void check_result(logic [RSP_W-1:0] actual);
         logic [RSP_W-1:0] expected;
         if (expected_widths.size() == 0) begin
            errors++;
            $display("%0t: result with none expected, got %h", $time, actual);
            return;
         end
         expected = expected_widths.pop_front();
         checked++;
         for (int k = 0; k < NUM_OUT; k++) begin
            if (actual[k*PW_W +: PW_W] !== expected[k*PW_W +: PW_W]) begin
               errors++;
               $display("%0t: width_m%0d expected %0d, got %0d", $time, k + 1,
                        expected[k*PW_W +: PW_W], actual[k*PW_W +: PW_W]);
            end
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata;
   logic                req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                csr_we;
   logic [CSR_A_W-1:0]  csr_addr;
   logic [PW_W-1:0]     csr_wdata;

   mix_scoreboard board;
   logic          quiet;
   int            stall_left;
   int            idle_cycles;
   int            items_sent;
   int            lost_items;
   int            manual_items;

   thruster_mixer_clamp_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // result side: check, then pick the next ready value
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata);
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 16) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, idle_cycles);
         $display("[thruster_mixer_clamp_top] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_cmd(req_type cmd, logic lost);
      req_tvalid <= 1'b1;
      req_tdata  <= cmd;
      req_tuser  <= lost;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_item(cmd, lost);
      items_sent++;
      if (lost) lost_items++;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.expected_widths.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_A_W-1:0] idx, pw_type value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.write_reg(idx, value);
   endtask

   task automatic set_limits(pw_type neutral, pw_type high, pw_type low, logic junk);
      write_csr(CSR_NEUTRAL, neutral);
      write_csr(CSR_CLAMP_HIGH, high);
      if (junk) write_csr(CSR_UNUSED, pw_type'($urandom));
      write_csr(CSR_CLAMP_LOW, low);
      csr_we <= 1'b0;
   endtask

   function automatic logic signed [CMD_W-1:0] random_stick();
      case ($urandom_range(0, 9))
         0:       return STICK_MIN;
         1:       return STICK_MAX;
         default: return CMD_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [CORR_W-1:0] random_corr();
      case ($urandom_range(0, 9))
         0:       return CORR_MIN;
         1:       return CORR_MAX;
         default: return CORR_W'($urandom);
      endcase
   endfunction

   task automatic send_random(int count);
      req_type cmd;
      logic    lost;
      for (int i = 0; i < count; i++) begin
         cmd.surge      = random_stick();
         cmd.sway       = random_stick();
         cmd.heave      = random_stick();
         cmd.turn       = random_stick();
         cmd.pitch_corr = random_corr();
         cmd.roll_corr  = random_corr();
         cmd.yaw_corr   = random_corr();
         // manual mode: no corrections
         if ($urandom_range(0, 7) == 0) begin
            cmd.pitch_corr = '0;
            cmd.roll_corr  = '0;
            cmd.yaw_corr   = '0;
            manual_items++;
         end
         lost = ($urandom_range(0, 7) == 0);
         send_cmd(cmd, lost);
      end
   endtask

   task automatic send_directed();
      req_type cmd;
      cmd = '0;
      send_cmd(cmd, 1'b0);
      cmd = '{CORR_MAX, CORR_MAX, CORR_MAX, STICK_MAX, STICK_MAX, STICK_MAX, STICK_MAX};
      send_cmd(cmd, 1'b0);
      send_cmd(cmd, 1'b1);
      cmd = '{CORR_MIN, CORR_MIN, CORR_MIN, STICK_MIN, STICK_MIN, STICK_MIN, STICK_MIN};
      send_cmd(cmd, 1'b0);
      send_cmd(cmd, 1'b1);
      cmd = '{CORR_MIN, CORR_MAX, CORR_MIN, STICK_MAX, STICK_MAX, STICK_MIN, STICK_MAX};
      send_cmd(cmd, 1'b0);
      cmd = '{CORR_MAX, CORR_MIN, CORR_MAX, STICK_MIN, STICK_MIN, STICK_MAX, STICK_MIN};
      send_cmd(cmd, 1'b0);
      for (int f = 0; f < 7; f++) begin
         for (int top = 0; top < 2; top++) begin
            cmd = '0;
            case (f)
               0: cmd.surge      = top ? STICK_MAX : STICK_MIN;
               1: cmd.sway       = top ? STICK_MAX : STICK_MIN;
               2: cmd.heave      = top ? STICK_MAX : STICK_MIN;
               3: cmd.turn       = top ? STICK_MAX : STICK_MIN;
               4: cmd.pitch_corr = top ? CORR_MAX : CORR_MIN;
               5: cmd.roll_corr  = top ? CORR_MAX : CORR_MIN;
               default: cmd.yaw_corr = top ? CORR_MAX : CORR_MIN;
            endcase
            send_cmd(cmd, 1'b0);
         end
      end
   endtask

   initial begin
      pw_type neutral_tbl[NUM_PHASES];
      pw_type high_tbl[NUM_PHASES];
      pw_type low_tbl[NUM_PHASES];
      neutral_tbl = '{NEUTRAL_RST, 16'd0, 16'd65535, 16'd2000, 16'd1500, 16'd32768, 16'd0,
                      16'd0};
      high_tbl    = '{CLAMP_HIGH_RST, 16'd65535, 16'd65535, 16'd1000, 16'd2000, 16'd34000,
                      16'd0, 16'd0};
      low_tbl     = '{CLAMP_LOW_RST, 16'd0, 16'd0, 16'd3000, 16'd1000, 16'd31000,
                      16'd65535, 16'd0};
      board        = new();
      quiet        = 1'b0;
      stall_left   = 0;
      items_sent   = 0;
      lost_items   = 0;
      manual_items = 0;
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= 1'b0;
      rsp_tready   <= 1'b0;
      csr_we       <= 1'b0;
      csr_addr     <= CSR_NEUTRAL;
      csr_wdata    <= '0;
      idle_cycles  <= 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_directed();
      send_random(ITEMS_PER_PHASE);
      for (int p = 1; p < NUM_PHASES; p++) begin
         drain();
         if (p == NUM_PHASES - 1) begin
            quiet = 1'b1;
            set_limits(pw_type'($urandom), pw_type'($urandom), pw_type'($urandom), 1'b1);
         end else begin
            set_limits(neutral_tbl[p], high_tbl[p], low_tbl[p], p == 3);
         end
         if (p == 2) begin
            send_random(ITEMS_PER_PHASE / 2);
            drain();
            send_random(ITEMS_PER_PHASE / 2);
         end else begin
            send_random(ITEMS_PER_PHASE);
         end
      end
      drain();

      if (board.expected_widths.size() != 0) begin
         board.errors++;
         $display("%0t: %0d results never arrived", $time, board.expected_widths.size());
      end
      $display("Covered %0d items (%0d link lost, %0d manual) over %0d limit settings,",
               items_sent, lost_items, manual_items, NUM_PHASES);
      $display("including crossed and full-range limits; %0d results checked, %0d mismatches.",
               board.checked, board.errors);
      if (board.errors == 0)
         $display("[thruster_mixer_clamp_top] OK");
      else
         $display("[thruster_mixer_clamp_top] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
